// ===== sv/gwmv_pkg.sv =====
package gwmv_pkg;

   localparam int COUNT_BINS = 16;
   localparam int BIN_W      = (COUNT_BINS > 1) ? $clog2(COUNT_BINS) : 1;
   localparam int SCAN_W     = BIN_W + 1;
   localparam int TALLY_W    = 6;
   localparam int ROWS_W     = 12;
   localparam int IDLE_W     = 8;
   localparam int WIN_W      = 6;
   localparam int COUNT_W    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [TALLY_W-1:0] BIN_MAX  = {TALLY_W{1'b1}};
   localparam logic [WIN_W-1:0]   WIN_MAX  = {WIN_W{1'b1}};
   localparam logic [IDLE_W-1:0]  IDLE_MAX = {IDLE_W{1'b1}};

   localparam logic [ROWS_W-1:0] FRAME_ROWS_RESET       = 12'd480;
   localparam logic [IDLE_W-1:0] IDLE_THRESHOLD_RESET   = 8'd12;
   localparam logic [WIN_W-1:0]  WINDOW_THRESHOLD_RESET = 6'd12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_ROWS       = 2'd0,
      CSR_IDLE_THRESHOLD   = 2'd1,
      CSR_WINDOW_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INC,
      ST_SCAN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [ROWS_W-1:0]  box_height;
      logic               is_hand;
      logic [COUNT_W-1:0] finger_count;
   } req_type;

   typedef struct packed {
      logic               gate_open;
      logic               vote_ready;
      logic [COUNT_W-1:0] voted_count;
   } rsp_type;

   typedef struct packed {
      logic             take;
      logic             first;
      logic [BIN_W-1:0] bin;
   } mode_ctl_type;

   function automatic logic [BIN_W-1:0] clamp_bin(input logic [COUNT_W-1:0] count);
      logic [BIN_W-1:0] result;
      if (int'(count) > COUNT_BINS - 1) begin
         result = BIN_W'(COUNT_BINS - 1);
      end else begin
         result = BIN_W'(count);
      end
      return result;
   endfunction

endpackage

// ===== sv/gwmv_ram.sv =====
module gwmv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/gwmv_mode_unit.sv =====
module gwmv_mode_unit (
   input  logic                          clock,
   input  gwmv_pkg::mode_ctl_type        ctl,
   input  logic [gwmv_pkg::TALLY_W-1:0]  tally,
   output logic [gwmv_pkg::BIN_W-1:0]    best_bin
);

   logic [gwmv_pkg::TALLY_W-1:0] best_tally_ff, best_tally_in;
   logic [gwmv_pkg::BIN_W-1:0]   best_bin_ff, best_bin_in;

   // strict greater keeps the smaller bin on a tie
   always_comb begin
      best_tally_in = best_tally_ff;
      best_bin_in   = best_bin_ff;
      if (ctl.take && (ctl.first || tally > best_tally_ff)) begin
         best_tally_in = tally;
         best_bin_in   = ctl.bin;
      end
   end

   always_ff @(posedge clock) begin
      best_tally_ff <= best_tally_in;
      best_bin_ff   <= best_bin_in;
   end

   assign best_bin = best_bin_ff;

endmodule

// ===== sv/gated_window_mode_vote.sv =====
// Finger-count vote over a window of qualifying video frames. One req_ transfer per frame
// gives exactly one rsp_ transfer. A frame that does not qualify goes straight to the
// output state, a collected frame first does a read-modify-write of its histogram bin,
// and a frame that closes a window then also scans all bins: the histogram sits in a RAM
// with one read and one write port and one comparator walks it a bin per cycle. No new
// frame is taken until the current one has been placed in the output register; a finished
// result may wait there while the next frame is worked on. Registers are written through
// csr_ (always ready) and should only change while the block is idle.
module gated_window_mode_vote (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gwmv_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gwmv_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gwmv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gwmv_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   gwmv_pkg::state_type state_ff, state_in;

   logic [gwmv_pkg::ROWS_W-1:0] frame_rows_ff, frame_rows_in;
   logic [gwmv_pkg::IDLE_W-1:0] idle_threshold_ff, idle_threshold_in;
   logic [gwmv_pkg::WIN_W-1:0]  window_threshold_ff, window_threshold_in;

   logic [gwmv_pkg::IDLE_W-1:0]    idle_count_ff, idle_count_in;
   logic [gwmv_pkg::WIN_W-1:0]     window_count_ff, window_count_in;
   logic [gwmv_pkg::COUNT_BINS-1:0] valid_ff, valid_in;
   logic [gwmv_pkg::BIN_W-1:0]     bin_ff, bin_in;
   logic [gwmv_pkg::SCAN_W-1:0]    scan_ff, scan_in;
   gwmv_pkg::rsp_type              res_ff, res_in;
   gwmv_pkg::rsp_type              rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic                          accept;
   logic                          qualify;
   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic [gwmv_pkg::BIN_W-1:0]    ram_rd_addr;
   logic [gwmv_pkg::TALLY_W-1:0]  ram_rd_data;
   logic [gwmv_pkg::TALLY_W-1:0]  bin_value;
   logic [gwmv_pkg::TALLY_W-1:0]  bin_next;
   logic [gwmv_pkg::BIN_W-1:0]    scan_prev;
   logic [gwmv_pkg::TALLY_W-1:0]  scan_tally;
   logic [gwmv_pkg::BIN_W-1:0]    best_bin;
   gwmv_pkg::mode_ctl_type        mode_ctl;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != gwmv_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign qualify = (req_payload.box_height > {1'b0, frame_rows_ff[gwmv_pkg::ROWS_W-1:1]})
                    && (idle_count_ff > idle_threshold_ff) && req_payload.is_hand;

   // a bin that was cleared reads as zero whatever the RAM holds
   assign bin_value = valid_ff[bin_ff] ? ram_rd_data : '0;
   assign bin_next  = (bin_value == gwmv_pkg::BIN_MAX) ? bin_value
                                                      : bin_value + 1'b1;

   assign scan_prev  = gwmv_pkg::BIN_W'(scan_ff - 1'b1);
   assign scan_tally = valid_ff[scan_prev] ? ram_rd_data : '0;

   assign ram_wr_en = (state_ff == gwmv_pkg::ST_INC);
   always_comb begin
      if (state_ff == gwmv_pkg::ST_IDLE) begin
         ram_rd_en   = accept;
         ram_rd_addr = gwmv_pkg::clamp_bin(req_payload.finger_count);
      end else begin
         ram_rd_en   = (state_ff == gwmv_pkg::ST_SCAN)
                       && (scan_ff < gwmv_pkg::SCAN_W'(gwmv_pkg::COUNT_BINS));
         ram_rd_addr = scan_ff[gwmv_pkg::BIN_W-1:0];
      end
   end

   always_comb begin
      mode_ctl.take  = (state_ff == gwmv_pkg::ST_SCAN) && (scan_ff != '0);
      mode_ctl.first = (scan_ff == gwmv_pkg::SCAN_W'(1));
      mode_ctl.bin   = scan_prev;
   end

   gwmv_ram #(
      .WIDTH (gwmv_pkg::TALLY_W),
      .DEPTH (gwmv_pkg::COUNT_BINS)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (bin_ff),
      .wr_data (bin_next),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gwmv_mode_unit u_mode (
      .clock    (clock),
      .ctl      (mode_ctl),
      .tally    (scan_tally),
      .best_bin (best_bin)
   );

   // configuration writes
   always_comb begin
      frame_rows_in       = frame_rows_ff;
      idle_threshold_in   = idle_threshold_ff;
      window_threshold_in = window_threshold_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gwmv_pkg::CSR_FRAME_ROWS:
               frame_rows_in = csr_wdata[gwmv_pkg::ROWS_W-1:0];
            gwmv_pkg::CSR_IDLE_THRESHOLD:
               idle_threshold_in = csr_wdata[gwmv_pkg::IDLE_W-1:0];
            gwmv_pkg::CSR_WINDOW_THRESHOLD:
               window_threshold_in = csr_wdata[gwmv_pkg::WIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      idle_count_in   = idle_count_ff;
      window_count_in = window_count_ff;
      valid_in        = valid_ff;
      bin_in          = bin_ff;
      scan_in         = scan_ff;
      res_in          = res_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      case (state_ff)
         gwmv_pkg::ST_IDLE: begin
            if (accept) begin
               bin_in = gwmv_pkg::clamp_bin(req_payload.finger_count);
               res_in = '0;
               if (qualify) begin
                  state_in = gwmv_pkg::ST_INC;
               end else begin
                  if (idle_count_ff != gwmv_pkg::IDLE_MAX) begin
                     idle_count_in = idle_count_ff + 1'b1;
                  end
                  state_in = gwmv_pkg::ST_OUT;
               end
            end
         end
         gwmv_pkg::ST_INC: begin
            valid_in[bin_ff] = 1'b1;
            res_in.gate_open = 1'b1;
            if (window_count_ff > window_threshold_ff) begin
               res_in.vote_ready = 1'b1;
               scan_in           = '0;
               state_in          = gwmv_pkg::ST_SCAN;
            end else begin
               if (window_count_ff != gwmv_pkg::WIN_MAX) begin
                  window_count_in = window_count_ff + 1'b1;
               end
               state_in = gwmv_pkg::ST_OUT;
            end
         end
         gwmv_pkg::ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            // last bin compared this cycle: close the window
            if (scan_ff == gwmv_pkg::SCAN_W'(gwmv_pkg::COUNT_BINS)) begin
               valid_in        = '0;
               idle_count_in   = '0;
               window_count_in = '0;
               state_in        = gwmv_pkg::ST_OUT;
            end
         end
         gwmv_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in             = res_ff;
               rsp_in.voted_count = res_ff.vote_ready
                                    ? gwmv_pkg::COUNT_W'(best_bin) : '0;
               rsp_valid_in       = 1'b1;
               state_in           = gwmv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gwmv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= gwmv_pkg::ST_IDLE;
         frame_rows_ff       <= gwmv_pkg::FRAME_ROWS_RESET;
         idle_threshold_ff   <= gwmv_pkg::IDLE_THRESHOLD_RESET;
         window_threshold_ff <= gwmv_pkg::WINDOW_THRESHOLD_RESET;
         idle_count_ff       <= '0;
         window_count_ff     <= '0;
         valid_ff            <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         frame_rows_ff       <= frame_rows_in;
         idle_threshold_ff   <= idle_threshold_in;
         window_threshold_ff <= window_threshold_in;
         idle_count_ff       <= idle_count_in;
         window_count_ff     <= window_count_in;
         valid_ff            <= valid_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      scan_ff <= scan_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_vote_implies_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.vote_ready |-> rsp_ff.gate_open)
      else $error("vote reported on a frame that was not collected");

   a_no_vote_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.vote_ready |-> rsp_ff.voted_count == '0)
      else $error("voted count nonzero without a vote");

   a_scan_only_on_full_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == gwmv_pkg::ST_SCAN |-> window_count_ff > window_threshold_ff)
      else $error("histogram scan started before the window was full");

   a_window_cleared_after_vote: assert property (@(posedge clock) disable iff (reset)
      state_ff == gwmv_pkg::ST_OUT && res_ff.vote_ready
      |-> valid_ff == '0 && window_count_ff == '0 && idle_count_ff == '0)
      else $error("histogram or counters not cleared after a vote");
`endif

endmodule

// ===== test/gwmv_vote_checker.sv =====
module gwmv_vote_checker
   import gwmv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_payload,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    failures,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [ROWS_W-1:0]  rows_cfg;
   logic [IDLE_W-1:0]  idle_cfg;
   logic [WIN_W-1:0]   window_cfg;
   logic [IDLE_W-1:0]  idle_frames;
   logic [WIN_W-1:0]   window_frames;
   logic [TALLY_W-1:0] tally [COUNT_BINS];
   rsp_type            predicted_votes [$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   function automatic void clear_tally();
      for (int b = 0; b < COUNT_BINS; b++) begin
         tally[b] = '0;
      end
   endfunction

   function automatic rsp_type predict_vote(input req_type frame);
      rsp_type vote;
      int      bin;
      int      best;
      vote = '0;
      if (frame.box_height > (rows_cfg >> 1) && idle_frames > idle_cfg && frame.is_hand) begin
         vote.gate_open = 1'b1;
         bin = int'(frame.finger_count);
         if (bin > COUNT_BINS - 1) begin
            bin = COUNT_BINS - 1;
         end
         if (tally[bin] < BIN_MAX) begin
            tally[bin] = tally[bin] + 1'b1;
         end
         if (window_frames > window_cfg) begin
            // ties keep the lower bin since only a strictly larger tally wins
            best = 0;
            for (int b = 1; b < COUNT_BINS; b++) begin
               if (tally[b] > tally[best]) begin
                  best = b;
               end
            end
            vote.vote_ready  = 1'b1;
            vote.voted_count = COUNT_W'(best);
            clear_tally();
            idle_frames   = '0;
            window_frames = '0;
         end else if (window_frames < WIN_MAX) begin
            window_frames = window_frames + 1'b1;
         end
      end else if (idle_frames < IDLE_MAX) begin
         idle_frames = idle_frames + 1'b1;
      end
      return vote;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t checker: %s", $realtime, msg);
      failures++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type next_vote;
      if (reset) begin
         rows_cfg      = FRAME_ROWS_RESET;
         idle_cfg      = IDLE_THRESHOLD_RESET;
         window_cfg    = WINDOW_THRESHOLD_RESET;
         idle_frames   = '0;
         window_frames = '0;
         clear_tally();
         predicted_votes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            // only the low bits of a register survive, unknown indexes do nothing
            case (csr_index)
               CSR_FRAME_ROWS:       rows_cfg   = csr_wdata[ROWS_W-1:0];
               CSR_IDLE_THRESHOLD:   idle_cfg   = csr_wdata[IDLE_W-1:0];
               CSR_WINDOW_THRESHOLD: window_cfg = csr_wdata[WIN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_votes.size() == 0) begin
               report_mismatch($sformatf("result transfer %h with nothing pending",
                  rsp_payload));
            end else begin
               want = predicted_votes.pop_front();
               if (rsp_payload.gate_open !== want.gate_open) begin
                  report_mismatch($sformatf("gate_open got %b want %b",
                     rsp_payload.gate_open, want.gate_open));
               end
               if (rsp_payload.vote_ready !== want.vote_ready) begin
                  report_mismatch($sformatf("vote_ready got %b want %b",
                     rsp_payload.vote_ready, want.vote_ready));
               end
               if (rsp_payload.voted_count !== want.voted_count) begin
                  report_mismatch($sformatf("voted_count got %0d want %0d",
                     rsp_payload.voted_count, want.voted_count));
               end
            end
         end
         if (req_valid && !req_stall) begin
            next_vote       = predict_vote(req_payload);
            predicted_votes = {predicted_votes, next_vote};
         end
      end
      pending = predicted_votes.size();
   end

endmodule

// ===== test/gated_window_mode_vote_tb.sv =====
module gated_window_mode_vote_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gwmv_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1350;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    failures;
   int                    pending;

   int burst_left  = 0;
   bit quiet       = 1'b0;
   int frames_sent = 0;
   int stall_mode  = 0;
   int stall_left  = 0;

   gated_window_mode_vote dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   gwmv_vote_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .pending     (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver back-pressure: free, random, periodic, or long held runs
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 9) < 3);
         2:       rsp_stall <= ((stall_left % 7) < 3);
         default: rsp_stall <= ($urandom_range(0, 15) == 0) ? ~rsp_stall : rsp_stall;
      endcase
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_frame(input req_type frame);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = quiet ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= frame;
      do @(posedge clock); while (req_stall);
      frames_sent++;
   endtask

   // hold the sender off until every result is back
   task automatic drain_votes();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      wait (pending == 0);
   endtask

   function automatic req_type make_frame(input int half, input logic [COUNT_W-1:0] favorite,
         input bit dominant);
      req_type frame;
      int      pick;
      pick = $urandom_range(0, 99);
      frame.box_height   = ROWS_W'($urandom);
      frame.is_hand      = 1'($urandom);
      frame.finger_count = COUNT_W'($urandom);
      if (pick < 80) begin
         if (pick < 5) begin
            frame.box_height = {ROWS_W{1'b1}};
         end else if (pick < 10) begin
            frame.box_height = ROWS_W'(half + 1);
         end else begin
            frame.box_height = ROWS_W'($urandom_range(half + 1, (1 << ROWS_W) - 1));
         end
         frame.is_hand = 1'b1;
         if (dominant) begin
            if (pick < 72) begin
               frame.finger_count = favorite;
            end
         end else if (pick < 60) begin
            // a narrow spread of counts makes tied tallies common
            frame.finger_count = favorite + COUNT_W'($urandom_range(0, 2));
         end
      end else if (pick < 88) begin
         frame.box_height = ROWS_W'(half);
      end
      return frame;
   endfunction

   task automatic run_phase(input logic [ROWS_W-1:0] rows, input logic [IDLE_W-1:0] idle,
         input logic [WIN_W-1:0] win, input int frames, input bit dominant);
      logic [COUNT_W-1:0] favorite;
      drain_votes();
      // upper data bits are junk on purpose, the block keeps only the low bits
      write_reg(CSR_FRAME_ROWS, rows);
      write_reg(CSR_IDLE_THRESHOLD, {4'($urandom), idle});
      write_reg(CSR_WINDOW_THRESHOLD, {6'($urandom), win});
      if ($urandom_range(0, 2) == 0) begin
         write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      end
      quiet = ($urandom_range(0, 3) == 0);
      favorite = COUNT_W'($urandom);
      for (int i = 0; i < frames; i++) begin
         if ($urandom_range(0, 29) == 0) begin
            favorite = COUNT_W'($urandom);
         end
         send_frame(make_frame(int'(rows >> 1), favorite, dominant));
      end
   endtask

   initial begin
      req_type            frame;
      logic [ROWS_W-1:0]  rows;
      logic [IDLE_W-1:0]  idle;
      logic [WIN_W-1:0]   win;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: extremes of every field and the half-rows boundary
      for (int i = 0; i < 24; i++) begin
         case (i % 4)
            0:       frame.box_height = '0;
            1:       frame.box_height = {ROWS_W{1'b1}};
            2:       frame.box_height = ROWS_W'(int'(FRAME_ROWS_RESET) / 2);
            default: frame.box_height = ROWS_W'(int'(FRAME_ROWS_RESET) / 2 + 1);
         endcase
         frame.is_hand      = (i % 3 != 0);
         frame.finger_count = (i < 12) ? ((i % 2 != 0) ? '1 : '0) : COUNT_W'(i);
         send_frame(frame);
      end

      run_phase({ROWS_W{1'b1}}, '0, '0, 40, 1'b0);
      // largest idle threshold that can still open, idle counter runs to its top
      run_phase('0, 8'd254, 6'd5, 290, 1'b0);
      // idle threshold at its top: nothing qualifies
      run_phase(ROWS_W'($urandom), {IDLE_W{1'b1}}, 6'd3, 30, 1'b0);
      // long window dominated by one count
      run_phase(12'd300, '0, 6'd62, 80, 1'b1);
      // window counter at its top: no vote at all
      run_phase(12'd100, '0, {WIN_W{1'b1}}, 90, 1'b0);
      run_phase(12'd640, 8'd1, 6'd61, 70, 1'b0);

      while (frames_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 3))
            0:       rows = '0;
            1:       rows = {ROWS_W{1'b1}};
            default: rows = ROWS_W'($urandom);
         endcase
         idle = ($urandom_range(0, 4) == 0) ? IDLE_W'($urandom_range(0, 20))
                                            : IDLE_W'($urandom_range(0, 4));
         win  = WIN_W'($urandom_range(0, 10));
         run_phase(rows, idle, win, $urandom_range(60, 100), ($urandom_range(0, 3) == 0));
      end

      drain_votes();
      repeat (24) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("gated_window_mode_vote: match");
      end else begin
         $display("gated_window_mode_vote: mismatch");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("gated_window_mode_vote: mismatch");
      $finish;
   end

endmodule
